FILE: src/rvcore_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvcore_pkg: shared types and constants of the RV32E subset core
// Opcodes, function codes, memory geometry and the data memory request.
// ----------------------------------------------------------------------------
package rvcore_pkg;

  // Data memory geometry: byte addresses, four byte-wide banks
  localparam int MEM_ADDR_BITS = 16;
  localparam int ROW_BITS      = MEM_ADDR_BITS - 2;
  localparam int ROW_DEPTH     = 1 << ROW_BITS;
  localparam int BANK_COUNT    = 4;

  // Register file geometry
  localparam int XLEN      = 32;
  localparam int REG_BITS  = 4;
  localparam int REG_COUNT = 1 << REG_BITS;

  // Stream packing
  localparam int IN_DATA_BITS  = 56;
  localparam int OUT_DATA_BITS = 72;

  // Item kinds on the input stream
  localparam logic KIND_EXEC    = 1'b0;
  localparam logic KIND_PRELOAD = 1'b1;

  // Opcodes
  localparam logic [6:0] OPC_OPIMM = 7'h13;
  localparam logic [6:0] OPC_OP    = 7'h33;
  localparam logic [6:0] OPC_LUI   = 7'h37;
  localparam logic [6:0] OPC_LOAD  = 7'h03;
  localparam logic [6:0] OPC_STORE = 7'h23;
  localparam logic [6:0] OPC_JALR  = 7'h67;

  // funct3 codes
  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_SW  = 3'd2;
  localparam logic [2:0] F3_SB  = 3'd0;

  localparam logic [31:0]         EBREAK_WORD = 32'h0010_0073;
  localparam logic [REG_BITS-1:0] REG_A0      = 4'd10;
  localparam logic [REG_BITS-1:0] REG_ZERO    = 4'd0;

  typedef logic [MEM_ADDR_BITS-1:0] maddr_t;

  // One data memory access, issued as the item leaves the execute stage
  typedef struct packed {
    logic       rd;
    logic       wr;
    logic       word;
    maddr_t     addr;
    logic [XLEN-1:0] data;
  } dmem_req_t;

  function automatic logic [XLEN-1:0] sext12(input logic [11:0] v);
    return {{(XLEN-12){v[11]}}, v};
  endfunction

endpackage

FILE: src/rvcore_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvcore_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module rvcore_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/rvcore_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvcore_regfile: 16 x 32 register file with two registered read ports
// Valid bits give the all-zero reset; a write at the read edge is passed on.
// ----------------------------------------------------------------------------
module rvcore_regfile (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [rvcore_pkg::REG_BITS-1:0] rs1_idx,
  input  logic [rvcore_pkg::REG_BITS-1:0] rs2_idx,
  input  logic                          wr_en,
  input  logic [rvcore_pkg::REG_BITS-1:0] wr_idx,
  input  logic [rvcore_pkg::XLEN-1:0]     wr_data,
  output logic [rvcore_pkg::XLEN-1:0]     rs1_data,
  output logic [rvcore_pkg::XLEN-1:0]     rs2_data
);
  import rvcore_pkg::*;

  logic [REG_COUNT-1:0] valid;
  logic                 v1, v2, byp1, byp2;
  logic [XLEN-1:0]      bval1, bval2;
  logic [XLEN-1:0]      ram1_q, ram2_q;

  rvcore_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_ram1 (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rs1_idx),
    .rdata (ram1_q)
  );

  rvcore_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_ram2 (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rs2_idx),
    .rdata (ram2_q)
  );

  // Mark written entries; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  // Capture valid and same-edge write bypass alongside the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      byp1 <= 1'b0;
      byp2 <= 1'b0;
    end else if (rd_en) begin
      v1   <= valid[rs1_idx];
      v2   <= valid[rs2_idx];
      byp1 <= wr_en && (wr_idx == rs1_idx);
      byp2 <= wr_en && (wr_idx == rs2_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      bval1 <= wr_data;
      bval2 <= wr_data;
    end
  end

  // Select bypass, stored value or reset zero
  assign rs1_data = byp1 ? bval1 : (v1 ? ram1_q : '0);
  assign rs2_data = byp2 ? bval2 : (v2 ? ram2_q : '0);

endmodule

FILE: src/rvcore_dmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvcore_dmem: byte-addressed data memory in four byte banks
// Unaligned little-endian words touch each bank once; reads are registered.
// ----------------------------------------------------------------------------
module rvcore_dmem (
  input  logic                        clk,
  input  rvcore_pkg::dmem_req_t       req,
  output logic [rvcore_pkg::XLEN-1:0] load_data
);
  import rvcore_pkg::*;

  logic [1:0]          rel    [BANK_COUNT];
  maddr_t              baddr  [BANK_COUNT];
  logic [ROW_BITS-1:0] row    [BANK_COUNT];
  logic                bank_we[BANK_COUNT];
  logic [7:0]          wbyte  [BANK_COUNT];
  logic [7:0]          bank_q [BANK_COUNT];
  logic [7:0]          lbyte  [BANK_COUNT];
  logic [1:0]          off_q;
  logic                word_q;

  // Map each bank to the byte of the access that falls in it
  always_comb begin
    for (int i = 0; i < BANK_COUNT; i++) begin
      rel[i]     = 2'(i) - req.addr[1:0];
      baddr[i]   = req.addr + maddr_t'(rel[i]);
      row[i]     = baddr[i][MEM_ADDR_BITS-1:2];
      bank_we[i] = req.wr && (req.word || (rel[i] == 2'd0));
      case (rel[i])
        2'd0:    wbyte[i] = req.data[7:0];
        2'd1:    wbyte[i] = req.data[15:8];
        2'd2:    wbyte[i] = req.data[23:16];
        default: wbyte[i] = req.data[31:24];
      endcase
    end
  end

  for (genvar g = 0; g < BANK_COUNT; g++) begin : g_bank
    rvcore_ram #(.WIDTH(8), .DEPTH(ROW_DEPTH)) u_bank (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (row[g]),
      .wdata (wbyte[g]),
      .re    (req.rd),
      .raddr (row[g]),
      .rdata (bank_q[g])
    );
  end

  // Hold the byte offset and size of the read in flight
  always_ff @(posedge clk) begin
    if (req.rd) begin
      off_q  <= req.addr[1:0];
      word_q <= req.word;
    end
  end

  // Rotate bank outputs back into address order
  always_comb begin
    for (int k = 0; k < BANK_COUNT; k++) begin
      lbyte[k] = bank_q[off_q + 2'(k)];
    end
    load_data = word_q ? {lbyte[3], lbyte[2], lbyte[1], lbyte[0]}
                       : {24'b0, lbyte[0]};
  end

endmodule

FILE: src/rv32e_subset_core_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32e_subset_core_step_core: RV32E subset core, one instruction per beat
// Executes addi, add, lui, lw, lbu, sw, sb, jalr, ebreak; preloads data bytes.
//
//   channel | dir | tdata (low bit up)                           | tuser
//   s_*     | in  | instruction, preload_address, preload_byte   | kind
//   m_*     | out | next_pc, halted, trap_good, reg_write,       | -
//           |     | reg_index, reg_value                         |
//
// One beat accepted per cycle while the output is not stalled.
// Latency is set by the registered reads of the register file and of the
// data memory banks; results forward between stages, so no hazard stalls.
// Reset clears the PC and the register file valid bits; the
// data memory has no reset and no clearing pass.
// A stalled output holds the pipeline only as far back as it is full.
// ----------------------------------------------------------------------------
module rv32e_subset_core_step_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // instruction[31:0], preload_address[47:32], preload_byte[55:48]
  input  logic [rvcore_pkg::IN_DATA_BITS-1:0]  s_tdata,
  // kind
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // next_pc[31:0], halted[32], trap_good[33], reg_write[34],
  // reg_index[38:35], reg_value[70:39], zero[71]
  output logic [rvcore_pkg::OUT_DATA_BITS-1:0] m_tdata
);
  import rvcore_pkg::*;

  // Stage handshake
  logic out_free, s2_free, s1_adv, s2_adv, accept;

  // Execute stage
  logic            s1_v;
  logic            s1_kind;
  logic [31:0]     s1_ins;
  logic [15:0]     s1_paddr;
  logic [7:0]      s1_pbyte;
  logic [XLEN-1:0] pc, pc_next;

  // Write-back stage
  logic                s2_v, s2_we, s2_load, s2_halt, s2_good;
  logic [REG_BITS-1:0] s2_rd;
  logic [XLEN-1:0]     s2_val, s2_pc;

  // Output register
  logic                o_halt, o_good, o_we;
  logic [REG_BITS-1:0] o_rd;
  logic [XLEN-1:0]     o_pc, o_val;

  // Operands and decode
  logic [REG_BITS-1:0] in_rs1, s1_rs1, s1_rs2, s1_rdi;
  logic [XLEN-1:0]     rf_a, rf_b, op_a, op_b, wb_val, dm_load;
  logic [XLEN-1:0]     imm, sto, ex_val, jtgt, maddr_sum;
  logic [6:0]          op;
  logic [2:0]          f3;
  logic                ex_wr, ex_load, ex_word, ex_store, rd_ok, is_exec, ex_halt;
  dmem_req_t           dreq;

  // Advance each stage when the one after it is free
  assign out_free = !m_tvalid || m_tready;
  assign s2_free  = !s2_v || out_free;
  assign s2_adv   = s2_v && out_free;
  assign s1_adv   = s1_v && s2_free;
  assign s_tready = !s1_v || s2_free;
  assign accept   = s_tvalid && s_tready;

  // ebreak reads a0 through the first port for its status
  assign in_rs1 = (s_tdata[31:0] == EBREAK_WORD) ? REG_A0 : s_tdata[18:15];
  assign s1_rs1 = (s1_ins == EBREAK_WORD) ? REG_A0 : s1_ins[18:15];
  assign s1_rs2 = s1_ins[23:20];
  assign s1_rdi = s1_ins[10:7];

  rvcore_regfile u_regfile (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rs1_idx  (in_rs1),
    .rs2_idx  (s_tdata[23:20]),
    .wr_en    (s2_adv && s2_we),
    .wr_idx   (s2_rd),
    .wr_data  (wb_val),
    .rs1_data (rf_a),
    .rs2_data (rf_b)
  );

  rvcore_dmem u_dmem (
    .clk       (clk),
    .req       (dreq),
    .load_data (dm_load)
  );

  // Forward the write-back result into the execute stage
  assign wb_val = s2_load ? dm_load : s2_val;
  assign op_a   = (s2_v && s2_we && (s2_rd == s1_rs1)) ? wb_val : rf_a;
  assign op_b   = (s2_v && s2_we && (s2_rd == s1_rs2)) ? wb_val : rf_b;

  // Decode and execute
  always_comb begin
    op        = s1_ins[6:0];
    f3        = s1_ins[14:12];
    imm       = sext12(s1_ins[31:20]);
    sto       = sext12({s1_ins[31:25], s1_ins[11:7]});
    jtgt      = op_a + imm;
    maddr_sum = (op == OPC_STORE) ? (op_a + sto) : jtgt;
    is_exec   = (s1_kind == KIND_EXEC);
    ex_val    = '0;
    ex_wr     = 1'b0;
    ex_load   = 1'b0;
    ex_word   = 1'b0;
    ex_store  = 1'b0;
    pc_next   = pc + 32'd4;
    case (op)
      OPC_OPIMM: begin
        ex_val = jtgt;
        ex_wr  = 1'b1;
      end
      OPC_OP: begin
        if (f3 == F3_ADD) begin
          ex_val = op_a + op_b;
          ex_wr  = 1'b1;
        end
      end
      OPC_LUI: begin
        ex_val = {s1_ins[31:12], 12'b0};
        ex_wr  = 1'b1;
      end
      OPC_LOAD: begin
        if (f3 == F3_LW) begin
          ex_wr   = 1'b1;
          ex_load = 1'b1;
          ex_word = 1'b1;
        end else if (f3 == F3_LBU) begin
          ex_wr   = 1'b1;
          ex_load = 1'b1;
        end
      end
      OPC_STORE: begin
        if (f3 == F3_SW) begin
          ex_store = 1'b1;
          ex_word  = 1'b1;
        end else if (f3 == F3_SB) begin
          ex_store = 1'b1;
        end
      end
      OPC_JALR: begin
        ex_val  = pc + 32'd4;
        ex_wr   = 1'b1;
        pc_next = {jtgt[31:1], 1'b0};
      end
      default: begin
      end
    endcase
    if (!is_exec) begin
      pc_next = pc;
    end
    rd_ok   = is_exec && ex_wr && (s1_rdi != REG_ZERO);
    ex_halt = is_exec && (s1_ins == EBREAK_WORD);
  end

  // Issue the memory access as the item leaves the execute stage
  always_comb begin
    dreq.rd   = s1_adv && is_exec && ex_load;
    dreq.wr   = s1_adv && (!is_exec || ex_store);
    dreq.word = is_exec && ex_word;
    dreq.addr = is_exec ? maddr_sum[MEM_ADDR_BITS-1:0] : maddr_t'(s1_paddr);
    dreq.data = is_exec ? op_b : {24'b0, s1_pbyte};
  end

  // Execute stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s_tready) begin
      s1_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind  <= s_tuser;
      s1_ins   <= s_tdata[31:0];
      s1_paddr <= s_tdata[47:32];
      s1_pbyte <= s_tdata[55:48];
    end
  end

  // Program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (s1_adv) begin
      pc <= pc_next;
    end
  end

  // Write-back stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v  <= 1'b0;
      s2_we <= 1'b0;
    end else if (s2_free) begin
      s2_v  <= s1_v;
      s2_we <= s1_v && rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_load <= rd_ok && ex_load;
      s2_rd   <= rd_ok ? s1_rdi : REG_ZERO;
      s2_val  <= (rd_ok && !ex_load) ? ex_val : '0;
      s2_pc   <= pc_next;
      s2_halt <= ex_halt;
      s2_good <= ex_halt && (op_a == '0);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      o_pc   <= s2_pc;
      o_halt <= s2_halt;
      o_good <= s2_good;
      o_we   <= s2_we;
      o_rd   <= s2_rd;
      o_val  <= wb_val;
    end
  end

  assign m_tdata = {1'b0, o_val, o_rd, o_we, o_good, o_halt, o_pc};

  // Checks
  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    (s2_adv && s2_we) |-> (s2_rd != REG_ZERO))
    else $error("write-back targets x0");

  a_preload_quiet: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && (s1_kind == KIND_PRELOAD)) |=> (!s2_we && !s2_halt && !s2_load))
    else $error("preload beat produced a write or halt");

  a_pc_holds: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> $stable(pc))
    else $error("pc moved without an executed beat");

  a_halt_no_write: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_halt) |-> !o_we)
    else $error("halt result carries a register write");

endmodule
